### src/nss_pkg.sv
// Shared types and constants for the nearest site search unit.
// No dependencies; used by the input stage, search engine and top module by scoped name.
package nss_pkg;

    localparam int SLOT_W  = 6;
    localparam int ID_W    = 6;
    localparam int COUNT_W = 7;
    localparam int DIST_W  = 34;

    // request kinds on the input tuser bit 0
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // control part of one queued request (coordinates travel beside it)
    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   site_id;
    } nss_cmd_t;

endpackage

### src/nss_front.sv
// Input stage: takes stream requests, unpacks them and drops the ones
// that need no work (skipped queries, loads outside the table).
// Depends on nss_pkg.
module nss_front #(
    parameter int MAX_SITES  = 64,
    parameter int COORD_BITS = 16,
    parameter int IN_DW      = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [IN_DW-1:0]            s_axis_tdata,
    input  logic [1:0]                  s_axis_tuser,
    output logic                        q_valid,
    input  logic                        q_ready,
    output nss_pkg::nss_cmd_t           q_cmd,
    output logic [2:0][COORD_BITS-1:0]  q_coord
);

    localparam int CB = COORD_BITS;

    logic                        vld_reg, vld_next;
    nss_pkg::nss_cmd_t           cmd_reg;
    logic [2:0][CB-1:0]          coord_reg;
    nss_pkg::nss_cmd_t           in_cmd;
    logic [2:0][CB-1:0]          in_coord;
    logic                        in_keep;
    logic                        take;

    always_comb
    begin
        in_cmd.op      = s_axis_tuser[0];
        in_cmd.slot    = s_axis_tdata[nss_pkg::SLOT_W-1:0];
        in_cmd.site_id = s_axis_tdata[nss_pkg::SLOT_W +: nss_pkg::ID_W];
        for (int a = 0; a < 3; a++)
        begin
            in_coord[a] = s_axis_tdata[nss_pkg::SLOT_W + nss_pkg::ID_W + a*CB +: CB];
        end
        if (in_cmd.op == nss_pkg::OP_LOAD)
            in_keep = (32'(in_cmd.slot) < MAX_SITES);
        else
            in_keep = !s_axis_tuser[1];
    end

    assign s_axis_tready = !vld_reg || q_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
            vld_next = in_keep;
        else if (q_ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg   <= in_cmd;
            coord_reg <= in_coord;
        end
    end

    assign q_valid = vld_reg;
    assign q_cmd   = cmd_reg;
    assign q_coord = coord_reg;

endmodule

### src/nss_fifo.sv
// Short request queue between the input stage and the search engine.
// No package dependencies.
module nss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_pop,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] buf_reg [DEPTH];
    logic [PW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = (cnt_reg != CW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_data  = buf_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        if (pop)
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wp_reg] <= wr_data;
    end

endmodule

### src/nss_back.sv
// Search engine: site table memory, pipelined distance scan, best-match
// tracking and the result register. Depends on nss_pkg.
module nss_back #(
    parameter int MAX_SITES  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [nss_pkg::COUNT_W-1:0]     active_sites,
    input  logic                            q_valid,
    output logic                            q_pop,
    input  nss_pkg::nss_cmd_t               q_cmd,
    input  logic [2:0][COORD_BITS-1:0]      q_coord,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [nss_pkg::ID_W+nss_pkg::DIST_W-1:0] m_axis_tdata,
    output logic                            m_axis_tuser
);

    localparam int CB    = COORD_BITS;
    localparam int IW    = nss_pkg::ID_W;
    localparam int DW    = nss_pkg::DIST_W;
    localparam int AW    = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int CNT_W = $clog2(MAX_SITES + 1);
    localparam int CMP_W = (CNT_W > nss_pkg::COUNT_W) ? CNT_W : nss_pkg::COUNT_W;
    localparam int SQ_W  = 2 * CB + 2;
    localparam int EW    = IW + 3 * CB;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [EW-1:0]          mem [MAX_SITES];

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       cnt_clamp;
    logic [CMP_W-1:0]       req_ext;
    logic [2:0][CB-1:0]     qpt_reg;

    logic                   issue;
    logic                   do_load, do_query;

    logic                   rd_v_reg, sq_v_reg, sum_v_reg;
    logic [EW-1:0]          rd_data_reg;
    logic [2:0][SQ_W-1:0]   sq_reg;
    logic [IW-1:0]          sq_id_reg, sum_id_reg;
    logic [SQ_W-1:0]        sum_reg;

    logic [2:0][SQ_W-1:0]   sq_calc;
    logic                   best_found_reg;
    logic [SQ_W-1:0]        best_d_reg;
    logic [IW-1:0]          best_id_reg;
    logic                   better;

    logic                   out_vld_reg, out_vld_next;
    logic                   out_found_reg;
    logic [IW-1:0]          out_id_reg;
    logic [DW-1:0]          out_d_reg;
    logic                   out_load;

    assign req_ext   = CMP_W'(active_sites);
    assign cnt_clamp = (req_ext > CMP_W'(MAX_SITES)) ? CNT_W'(MAX_SITES) : CNT_W'(req_ext);

    assign q_pop    = q_valid && (state_reg == ST_IDLE);
    assign do_load  = q_pop && (q_cmd.op == nss_pkg::OP_LOAD);
    assign do_query = q_pop && (q_cmd.op == nss_pkg::OP_QUERY);
    assign issue    = (state_reg == ST_SCAN) && (idx_reg != cnt_reg);
    assign out_load = (state_reg == ST_DONE) && (!out_vld_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (do_query)
                begin
                    idx_next   = '0;
                    cnt_next   = cnt_clamp;
                    state_next = (cnt_clamp == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                    idx_next = idx_reg + 1'b1;
                else
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !sq_v_reg && !sum_v_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // table memory: load writes only while idle, scan reads only later
    always_ff @(posedge clk)
    begin
        if (do_load)
            mem[AW'(q_cmd.slot)] <= {q_coord, q_cmd.site_id};
        if (issue)
            rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    // squared differences per axis from the registered table entry
    always_comb
    begin
        logic signed [CB:0] diff;
        logic        [CB:0] mag;
        for (int a = 0; a < 3; a++)
        begin
            diff = $signed({qpt_reg[a][CB-1], qpt_reg[a]})
                 - $signed({rd_data_reg[IW + a*CB + CB - 1], rd_data_reg[IW + a*CB +: CB]});
            mag  = diff[CB] ? (CB+1)'(-diff) : (CB+1)'(diff);
            sq_calc[a] = SQ_W'(mag) * SQ_W'(mag);
        end
    end

    assign better = !best_found_reg || (sum_reg < best_d_reg);

    always_ff @(posedge clk)
    begin
        if (do_query)
            qpt_reg <= q_coord;
        if (rd_v_reg)
        begin
            sq_reg    <= sq_calc;
            sq_id_reg <= rd_data_reg[IW-1:0];
        end
        if (sq_v_reg)
        begin
            sum_reg    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sum_id_reg <= sq_id_reg;
        end
        if (sum_v_reg && better)
        begin
            best_d_reg  <= sum_reg;
            best_id_reg <= sum_id_reg;
        end
        if (out_load)
        begin
            out_found_reg <= best_found_reg;
            out_id_reg    <= best_found_reg ? best_id_reg : '0;
            out_d_reg     <= best_found_reg ? DW'(best_d_reg) : '0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
            out_vld_next = 1'b1;
        else if (m_axis_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            rd_v_reg       <= 1'b0;
            sq_v_reg       <= 1'b0;
            sum_v_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            rd_v_reg  <= issue;
            sq_v_reg  <= rd_v_reg;
            sum_v_reg <= sq_v_reg;
            if (do_query)
                best_found_reg <= 1'b0;
            else if (sum_v_reg)
                best_found_reg <= 1'b1;
            out_vld_reg <= out_vld_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_d_reg, out_id_reg};
    assign m_axis_tuser  = out_found_reg;

endmodule

### src/nearest_site_search_unit.sv
// Nearest site search unit: brute-force nearest neighbor over a site table.
// Input side takes load and query requests on s_axis; a load writes one table
// slot, a query returns the closest site's id and squared distance on m_axis.
// The single config register active_sites is written through cfg_we/cfg_wdata
// and sets how many slots, from slot zero, a query scans (clamped to MAX_SITES).
// Loads and skipped queries give no result.
// Loads drain at one per cycle while the engine is idle. A query runs the search
// engine over N = clamped active_sites slots, and the table memory delivers one
// site per cycle to the distance pipeline; with no active site the scan is skipped.
// A four-entry request queue sits between the input stage and the engine, so
// requests keep being accepted while a search runs or a result waits.
// If the receiver stalls, the result holds in its output register and the
// engine stops before posting the next one; the queue then fills and
// s_axis_tready drops.
// Reset (rst_n low) empties the queue and pipeline and clears active_sites;
// table contents are undefined until loaded.
module nearest_site_search_unit #(
    parameter int MAX_SITES  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // slot, site_id, coord_x, coord_y, coord_z, zero fill
    input  logic [((12 + 3*COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // cmd, skip
    input  logic [1:0]                               s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // nearest_id, min_sq_distance
    output logic [nss_pkg::ID_W+nss_pkg::DIST_W-1:0] m_axis_tdata,
    // found
    output logic                                     m_axis_tuser,
    input  logic                                     cfg_we,
    input  logic [nss_pkg::COUNT_W-1:0]              cfg_wdata
);

    localparam int IN_DW = ((12 + 3*COORD_BITS + 7) / 8) * 8;
    localparam int QW    = $bits(nss_pkg::nss_cmd_t) + 3 * COORD_BITS;

    logic [nss_pkg::COUNT_W-1:0]    active_sites_reg;

    logic                           fr_valid, fr_ready;
    nss_pkg::nss_cmd_t              fr_cmd;
    logic [2:0][COORD_BITS-1:0]     fr_coord;

    logic                           bk_valid, bk_pop;
    logic [QW-1:0]                  bk_data;
    nss_pkg::nss_cmd_t              bk_cmd;
    logic [2:0][COORD_BITS-1:0]     bk_coord;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_sites_reg <= '0;
        else if (cfg_we)
            active_sites_reg <= cfg_wdata;
    end

    nss_front #(
        .MAX_SITES  (MAX_SITES),
        .COORD_BITS (COORD_BITS),
        .IN_DW      (IN_DW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (fr_valid),
        .q_ready       (fr_ready),
        .q_cmd         (fr_cmd),
        .q_coord       (fr_coord)
    );

    nss_fifo #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  ({fr_coord, fr_cmd}),
        .rd_valid (bk_valid),
        .rd_pop   (bk_pop),
        .rd_data  (bk_data)
    );

    assign bk_cmd   = bk_data[$bits(nss_pkg::nss_cmd_t)-1:0];
    assign bk_coord = bk_data[QW-1:$bits(nss_pkg::nss_cmd_t)];

    nss_back #(
        .MAX_SITES  (MAX_SITES),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .active_sites  (active_sites_reg),
        .q_valid       (bk_valid),
        .q_pop         (bk_pop),
        .q_cmd         (bk_cmd),
        .q_coord       (bk_coord),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
